### rtl/core/ikf_pkg.sv
// ----------------------------------------------------------------------------
// ikf_pkg
// shared constants, codes and tables of the tilt kalman fusion block
// ----------------------------------------------------------------------------
package ikf_pkg;

    // cordic and angle formats
    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int EXTRA_BITS      = 8;
    localparam int STEP_CW         = $clog2(CORDIC_STEPS + 1);
    localparam int TAB_IW          = 5;

    // datapath widths
    localparam int CW     = 34;   // cordic x and y
    localparam int ZW     = 32;   // cordic angle, degrees q.20
    localparam int MAW    = 34;   // multiplier operand a
    localparam int MBW    = 32;   // multiplier operand b
    localparam int MPW    = MAW + MBW;
    localparam int DIV_QW = 24;
    localparam int DIV_NW = 33;
    localparam int DIV_DW = 35;
    localparam int DIV_CW = $clog2(DIV_QW + 1);

    // fixed-point constants
    localparam logic [MBW-1:0] GAIN_INV_Q30 = MBW'(652032874);
    localparam logic [MBW-1:0] DT_Q32       = MBW'(17179869);
    localparam logic [31:0]    NOISE_Q24    = 32'd4295;
    localparam logic [31:0]    MEAS_VAR_Q24 = 32'd150994944;
    localparam logic [31:0]    P_INIT_Q24   = 32'd67108864;
    localparam logic [24:0]    ONE_Q24      = 25'd16777216;

    // register indexes
    localparam logic [2:0] REG_AX_OFS  = 3'd0;
    localparam logic [2:0] REG_AY_OFS  = 3'd1;
    localparam logic [2:0] REG_AZ_OFS  = 3'd2;
    localparam logic [2:0] REG_GX_OFS  = 3'd3;
    localparam logic [2:0] REG_GY_OFS  = 3'd4;
    localparam logic [2:0] REG_GZ_OFS  = 3'd5;
    localparam logic [2:0] REG_YAW_THR = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C1_GO,
        ST_C1_WT,
        ST_GAIN_MUL,
        ST_C2_GO,
        ST_C2_WT,
        ST_RATE_MUL,
        ST_DIV_GO,
        ST_DIV_WT,
        ST_KGAIN_MUL,
        ST_UNC_MUL,
        ST_UNC_WR,
        ST_DONE
    } t_state;

    // atan(2^-i) in degrees q.20
    function automatic logic [ZW-1:0] atan_q20(input logic [TAB_IW-1:0] i);
        logic [ZW-1:0] v;
        unique case (i)
            5'd0:    v = ZW'(47185920);
            5'd1:    v = ZW'(27855475);
            5'd2:    v = ZW'(14718068);
            5'd3:    v = ZW'(7471121);
            5'd4:    v = ZW'(3750058);
            5'd5:    v = ZW'(1876857);
            5'd6:    v = ZW'(938658);
            5'd7:    v = ZW'(469357);
            5'd8:    v = ZW'(234682);
            5'd9:    v = ZW'(117342);
            5'd10:   v = ZW'(58671);
            5'd11:   v = ZW'(29335);
            5'd12:   v = ZW'(14668);
            5'd13:   v = ZW'(7334);
            5'd14:   v = ZW'(3667);
            5'd15:   v = ZW'(1833);
            5'd16:   v = ZW'(917);
            5'd17:   v = ZW'(458);
            5'd18:   v = ZW'(229);
            5'd19:   v = ZW'(115);
            5'd20:   v = ZW'(57);
            5'd21:   v = ZW'(29);
            5'd22:   v = ZW'(14);
            5'd23:   v = ZW'(7);
            5'd24:   v = ZW'(4);
            5'd25:   v = ZW'(2);
            5'd26:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/ikf_mul.sv
// ----------------------------------------------------------------------------
// ikf_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module ikf_mul (
    input  logic                              i_clk,
    input  logic signed [ikf_pkg::MAW-1:0]    i_a,
    input  logic signed [ikf_pkg::MBW-1:0]    i_b,
    output logic signed [ikf_pkg::MPW-1:0]    o_p
);
    import ikf_pkg::*;

    logic signed [MPW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

### rtl/core/ikf_cordic.sv
// ----------------------------------------------------------------------------
// ikf_cordic
// iterative cordic vectoring, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module ikf_cordic (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [ikf_pkg::CW-1:0]   i_x,
    input  logic signed [ikf_pkg::CW-1:0]   i_y,
    output logic                            o_done,
    output logic signed [ikf_pkg::CW-1:0]   o_mag,
    output logic signed [ikf_pkg::ZW-1:0]   o_ang
);
    import ikf_pkg::*;

    logic signed [CW-1:0]  r_x, r_y;
    logic signed [ZW-1:0]  r_z;
    logic [STEP_CW-1:0]    r_cnt;
    logic                  r_busy, r_done, r_zero;
    logic signed [CW-1:0]  w_xs, w_ys;
    logic [ZW-1:0]         w_atan;

    assign w_xs   = r_x >>> r_cnt;
    assign w_ys   = r_y >>> r_cnt;
    assign w_atan = atan_q20(TAB_IW'(r_cnt));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x;
                r_y    <= i_y;
                r_z    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
                r_zero <= (i_x == '0) && (i_y == '0);
            end else if (r_busy) begin
                // rotate toward the x axis
                if (!r_y[CW-1]) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + $signed(w_atan);
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - $signed(w_atan);
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_CW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_mag  = r_x;
    assign o_ang  = r_zero ? '0 : r_z;

endmodule

### rtl/core/ikf_div.sv
// ----------------------------------------------------------------------------
// ikf_div
// restoring divider for the kalman gain, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ikf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ikf_pkg::DIV_NW-1:0]    i_num,
    input  logic [ikf_pkg::DIV_DW-1:0]    i_den,
    output logic                          o_done,
    output logic [ikf_pkg::DIV_QW-1:0]    o_quo
);
    import ikf_pkg::*;

    logic [DIV_DW:0]     r_rem;
    logic [DIV_DW-1:0]   r_den;
    logic [DIV_QW-1:0]   r_quo;
    logic [DIV_CW-1:0]   r_cnt;
    logic                r_busy, r_done;
    logic [DIV_DW:0]     w_try;
    logic                w_ge;

    // numerator is below the divisor, so remainder stays under it
    assign w_try = {r_rem[DIV_DW-1:0], 1'b0};
    assign w_ge  = w_try >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= (DIV_DW + 1)'(i_num);
                r_den  <= i_den;
                r_quo  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_try - {1'b0, r_den}) : w_try;
                r_quo <= {r_quo[DIV_QW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### rtl/core/imu_tilt_kalman_fusion.sv
// ----------------------------------------------------------------------------
// imu_tilt_kalman_fusion
// roll, pitch and yaw fusion of a six-axis sample with a scalar kalman per axis
// ----------------------------------------------------------------------------
// One input word carries a six-axis sample; one output word carries roll,
// pitch and yaw in degrees q.8. Offsets are subtracted, roll and pitch come
// from two cordic vectoring passes each, yaw is measured from the previous
// estimate plus the gyro increment above a threshold, and each axis then runs
// a scalar kalman step. The input is taken only in the idle state. One sample
// runs four cordic passes with their set-up states, then three kalman steps,
// each set mostly by the gain divider. A finished word waits in the output
// register while the next sample is already taken. Offsets and the yaw
// threshold are to be written through the plain write port only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module imu_tilt_kalman_fusion (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration write port
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_addr,
    input  logic [16:0]   i_cfg_wdata,
    // sample stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // accel_x[16:0] accel_y[33:17] accel_z[50:34] rate_x[66:51]
    // rate_y[82:67] rate_z[98:83], zero pad to 104
    input  logic [103:0]  s_axis_tdata,
    // angle stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // roll_angle[23:0] pitch_angle[47:24] yaw_angle[71:48]
    output logic [71:0]   m_axis_tdata
);
    import ikf_pkg::*;

    localparam int MEAS_SH = 20 - (ANGLE_FRAC_BITS + EXTRA_BITS);
    localparam int RATE_SH = 36 - (ANGLE_FRAC_BITS + EXTRA_BITS);
    localparam int UW      = MPW - 24;

    // configuration registers
    logic signed [16:0] r_ofs_ax, r_ofs_ay, r_ofs_az;
    logic signed [15:0] r_ofs_gx, r_ofs_gy, r_ofs_gz;
    logic [14:0]        r_yaw_thr;

    // corrected sample
    logic signed [17:0] r_cax, r_cay, r_caz;
    logic signed [16:0] r_cgx, r_cgy, r_cgz;

    // filter state
    logic signed [23:0] r_est [3];
    logic [31:0]        r_unc [3];

    // working registers
    t_state                r_state, n_state;
    logic [1:0]            r_ax;
    logic signed [MAW-1:0] r_meas [3];
    logic signed [MAW-1:0] r_pred;
    logic [DIV_NW-1:0]     r_p;
    logic [DIV_QW-1:0]     r_k;
    logic                  r_ovalid;
    logic [71:0]           r_odata;

    // unit hookups
    logic                   w_c_start, w_c_done;
    logic signed [CW-1:0]   w_c_x, w_c_y, w_c_mag;
    logic signed [ZW-1:0]   w_c_ang;
    logic                   w_d_start, w_d_done;
    logic [DIV_NW-1:0]      w_d_num;
    logic [DIV_DW-1:0]      w_d_den;
    logic [DIV_QW-1:0]      w_d_quo;
    logic signed [MAW-1:0]  w_m_a;
    logic signed [MBW-1:0]  w_m_b;
    logic signed [MPW-1:0]  w_prod;

    // tilt operand selection: roll on axis 0, pitch on axis 1
    logic [17:0]           w_b_abs, w_c_abs;
    logic signed [17:0]    w_num;
    logic signed [MAW-1:0] w_meas_new;
    logic signed [MAW-1:0] w_rs, w_pred_new;
    logic signed [16:0]    w_rate;
    logic [16:0]           w_gz_abs;
    logic signed [UW-1:0]  w_upd, w_rnd;
    logic signed [23:0]    w_est_new;
    logic                  w_accept, w_out_free;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_ovalid || m_axis_tready;

    always_comb begin
        w_b_abs = (r_ax == 2'd0) ? (r_cax[17] ? 18'(-r_cax) : r_cax)
                                 : (r_cay[17] ? 18'(-r_cay) : r_cay);
        w_c_abs = r_caz[17] ? 18'(-r_caz) : r_caz;
        w_num   = (r_ax == 2'd0) ? r_cay : r_cax;
    end

    // measured angle from q.20 degrees, pitch negated
    always_comb begin
        logic signed [MAW-1:0] ang;
        ang = (r_ax == 2'd0) ? MAW'(w_c_ang) : -MAW'(w_c_ang);
        if (MEAS_SH > 0)
            w_meas_new = (ang + (MAW'(1) <<< (MEAS_SH - 1))) >>> MEAS_SH;
        else
            w_meas_new = ang <<< (-MEAS_SH);
    end

    // rate increment, half-up rounded
    always_comb begin
        logic signed [MPW-1:0] t;
        t          = (w_prod + (MPW'(1) <<< (RATE_SH - 1))) >>> RATE_SH;
        w_rs       = MAW'(t);
        w_pred_new = (MAW'(r_est[r_ax]) <<< EXTRA_BITS) + w_rs;
    end

    always_comb begin
        unique case (r_ax)
            2'd0:    w_rate = r_cgx;
            2'd1:    w_rate = r_cgy;
            default: w_rate = r_cgz;
        endcase
        w_gz_abs = r_cgz[16] ? 17'(-r_cgz) : r_cgz;
    end

    // correction and rounding back to the output format
    always_comb begin
        w_upd = UW'(r_pred) + w_prod[MPW-1:24];
        w_rnd = (w_upd + (UW'(1) <<< (EXTRA_BITS - 1))) >>> EXTRA_BITS;
        if (w_rnd > UW'(8388607))
            w_est_new = 24'sh7FFFFF;
        else if (w_rnd < -UW'(8388608))
            w_est_new = -24'sh800000;
        else
            w_est_new = w_rnd[23:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (w_accept) n_state = ST_C1_GO;
            ST_C1_GO:     n_state = ST_C1_WT;
            ST_C1_WT:     if (w_c_done) n_state = ST_GAIN_MUL;
            ST_GAIN_MUL:  n_state = ST_C2_GO;
            ST_C2_GO:     n_state = ST_C2_WT;
            ST_C2_WT: begin
                if (w_c_done) n_state = (r_ax == 2'd0) ? ST_C1_GO : ST_RATE_MUL;
            end
            ST_RATE_MUL:  n_state = ST_DIV_GO;
            ST_DIV_GO:    n_state = ST_DIV_WT;
            ST_DIV_WT:    if (w_d_done) n_state = ST_KGAIN_MUL;
            ST_KGAIN_MUL: n_state = ST_UNC_MUL;
            ST_UNC_MUL:   n_state = ST_UNC_WR;
            ST_UNC_WR:    n_state = (r_ax == 2'd2) ? ST_DONE : ST_RATE_MUL;
            ST_DONE:      if (w_out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // unit controls and operands
    always_comb begin
        s_axis_tready = 1'b0;
        w_c_start     = 1'b0;
        w_c_x         = '0;
        w_c_y         = '0;
        w_d_start     = 1'b0;
        w_d_num       = DIV_NW'(r_unc[r_ax]) + DIV_NW'(NOISE_Q24);
        w_d_den       = DIV_DW'(w_d_num) + DIV_DW'(MEAS_VAR_Q24);
        w_m_a         = '0;
        w_m_b         = '0;
        unique case (r_state)
            ST_IDLE:      s_axis_tready = 1'b1;
            ST_C1_GO: begin
                w_c_start = 1'b1;
                w_c_x     = CW'({w_b_abs, 12'b0});
                w_c_y     = CW'({w_c_abs, 12'b0});
            end
            ST_GAIN_MUL: begin
                w_m_a = MAW'(w_c_mag);
                w_m_b = $signed(GAIN_INV_Q30);
            end
            ST_C2_GO: begin
                w_c_start = 1'b1;
                w_c_x     = $signed(w_prod[CW+29:30]);
                w_c_y     = CW'($signed({w_num, 12'b0}));
            end
            ST_RATE_MUL: begin
                w_m_a = MAW'(w_rate);
                w_m_b = $signed(DT_Q32);
            end
            ST_DIV_GO:    w_d_start = 1'b1;
            ST_KGAIN_MUL: begin
                w_m_a = r_meas[r_ax] - r_pred;
                w_m_b = $signed(MBW'(r_k));
            end
            ST_UNC_MUL: begin
                w_m_a = $signed(MAW'(r_p));
                w_m_b = $signed(MBW'(ONE_Q24 - 25'(r_k)));
            end
            default: ;
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofs_ax  <= '0;
            r_ofs_ay  <= '0;
            r_ofs_az  <= '0;
            r_ofs_gx  <= '0;
            r_ofs_gy  <= '0;
            r_ofs_gz  <= '0;
            r_yaw_thr <= 15'd80;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_AX_OFS:  r_ofs_ax  <= i_cfg_wdata;
                REG_AY_OFS:  r_ofs_ay  <= i_cfg_wdata;
                REG_AZ_OFS:  r_ofs_az  <= i_cfg_wdata;
                REG_GX_OFS:  r_ofs_gx  <= i_cfg_wdata[15:0];
                REG_GY_OFS:  r_ofs_gy  <= i_cfg_wdata[15:0];
                REG_GZ_OFS:  r_ofs_gz  <= i_cfg_wdata[15:0];
                REG_YAW_THR: r_yaw_thr <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ax     <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_est[i] <= '0;
                r_unc[i] <= P_INIT_Q24;
            end
        end else begin
            r_state <= n_state;
            // a new word may replace the one taken at this edge
            if (r_state == ST_DONE && w_out_free)
                r_ovalid <= 1'b1;
            else if (m_axis_tready)
                r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_ax  <= '0;
                        r_cax <= 18'($signed(s_axis_tdata[16:0])) - 18'(r_ofs_ax);
                        r_cay <= 18'($signed(s_axis_tdata[33:17])) - 18'(r_ofs_ay);
                        r_caz <= 18'($signed(s_axis_tdata[50:34])) - 18'(r_ofs_az);
                        r_cgx <= 17'($signed(s_axis_tdata[66:51])) - 17'(r_ofs_gx);
                        r_cgy <= 17'($signed(s_axis_tdata[82:67])) - 17'(r_ofs_gy);
                        r_cgz <= 17'($signed(s_axis_tdata[98:83])) - 17'(r_ofs_gz);
                    end
                end
                ST_C2_WT: begin
                    if (w_c_done) begin
                        r_meas[r_ax] <= w_meas_new;
                        r_ax         <= (r_ax == 2'd0) ? 2'd1 : 2'd0;
                    end
                end
                ST_DIV_GO: begin
                    r_pred <= w_pred_new;
                    r_p    <= w_d_num;
                    // yaw measurement: old estimate plus increment above threshold
                    if (r_ax == 2'd2)
                        r_meas[2] <= (MAW'(r_est[2]) <<< EXTRA_BITS)
                                   + ((w_gz_abs > 17'(r_yaw_thr)) ? w_rs : '0);
                end
                ST_DIV_WT:  if (w_d_done) r_k <= w_d_quo;
                ST_UNC_MUL: r_est[r_ax] <= w_est_new;
                ST_UNC_WR: begin
                    r_unc[r_ax] <= w_prod[55:24];
                    if (r_ax != 2'd2) r_ax <= r_ax + 2'd1;
                end
                ST_DONE: begin
                    if (w_out_free)
                        r_odata <= {r_est[2], r_est[1], r_est[0]};
                end
                default: ;
            endcase
        end
    end

    ikf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_c_start),
        .i_x     (w_c_x),
        .i_y     (w_c_y),
        .o_done  (w_c_done),
        .o_mag   (w_c_mag),
        .o_ang   (w_c_ang)
    );

    ikf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_d_start),
        .i_num   (w_d_num),
        .i_den   (w_d_den),
        .o_done  (w_d_done),
        .o_quo   (w_d_quo)
    );

    ikf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_m_a),
        .i_b   (w_m_b),
        .o_p   (w_prod)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule
